@@ sv/fqs_pkg.sv @@
package fqs_pkg;

  // Fixed field widths of the request and response channels
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OCC_W    = 5;

  // Defaults for the top-level parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Controller -> datapath
  typedef struct packed {
    logic    take;       // latch the search key
    logic    push_wr;    // write at tail, bump tail and count
    logic    rd_head;    // read the store at head
    logic    scan_init;  // start a scan after the head read
    logic    scan_step;  // read next scan entry
    logic    pop_done;   // retire head, capture the popped word
    logic    set_res;    // load the staged result
    status_e res_status;
    logic    res_pos;    // staged position comes from the scan counter
    logic    load_out;   // move staged result into the output register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/fqs_if.sv @@
interface fqs_req_if;
  import fqs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface fqs_rsp_if;
  import fqs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] removed_value;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output status, output position, output removed_value,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input position, input removed_value,
                  input occupancy, output ready);
endinterface

@@ sv/fqs_ram.sv @@
module fqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/fqs_ctrl.sv @@
module fqs_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [fqs_pkg::REQ_W-1:0] in_req_i,
  input  fqs_pkg::dp_stat_t        stat_i,
  output logic                     in_ready_o,
  output fqs_pkg::dp_cmd_t         cmd_o
);
  import fqs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_ready_o & in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_o.take = 1'b1;
          unique case (req_e'(in_req_i))
            REQ_PUSH: begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = stat_i.full ? ST_FULL : ST_OK;
              cmd_o.push_wr    = ~stat_i.full;
              state_d          = S_EMIT;
            end
            REQ_POP: begin
              if (stat_i.empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = ST_EMPTY;
                state_d          = S_EMIT;
              end else begin
                cmd_o.rd_head = 1'b1;
                state_d       = S_POP;
              end
            end
            REQ_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.set_res    = 1'b1;
                cmd_o.res_status = ST_EMPTY;
                state_d          = S_EMIT;
              end else begin
                cmd_o.rd_head   = 1'b1;
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: begin
              // unused code: no-op
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ST_OK;
              state_d          = S_EMIT;
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.pop_done   = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = ST_OK;
        state_d          = S_EMIT;
      end
      S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_pos    = 1'b1;
          state_d          = S_EMIT;
        end else if (stat_i.scan_last) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_EMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/fqs_dpath.sv @@
module fqs_dpath #(
  parameter int unsigned QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fqs_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [fqs_pkg::VALUE_W-1:0]  in_value_i,
  input  logic                                out_ready_i,
  output fqs_pkg::dp_stat_t                   stat_o,
  output logic                                out_valid_o,
  output logic [fqs_pkg::STATUS_W-1:0]        out_status_o,
  output logic [fqs_pkg::POS_W-1:0]           out_position_o,
  output logic signed [fqs_pkg::VALUE_W-1:0]  out_removed_o,
  output logic [fqs_pkg::OCC_W-1:0]           out_occupancy_o
);
  import fqs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  logic [IDX_W-1:0]      head_q, tail_q, scan_ptr_q;
  logic [CNT_W-1:0]      count_q, pos_q;
  logic [DATA_WIDTH-1:0] key_q, in_word, rd_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;

  status_e               res_status_q;
  logic [POS_W-1:0]      res_pos_q;
  logic [VALUE_W-1:0]    res_removed_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [POS_W-1:0]      out_pos_q;
  logic [VALUE_W-1:0]    out_removed_q;
  logic [OCC_W-1:0]      out_occ_q;

  assign in_word = DATA_WIDTH'($signed(in_value_i));
  assign rd_en   = cmd_i.rd_head | cmd_i.scan_step;
  assign rd_addr = cmd_i.rd_head ? head_q : scan_ptr_q;

  fqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.push_wr),
    .wr_addr_i (tail_q),
    .wr_data_i (in_word),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign stat_o.full      = (count_q == FULL_CNT);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.match     = (rd_data == key_q);
  assign stat_o.scan_last = (pos_q == count_q);
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  // queue pointers and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      scan_ptr_q <= '0;
      pos_q      <= '0;
    end else begin
      if (cmd_i.push_wr) begin
        tail_q  <= next_idx(tail_q);
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pop_done) begin
        head_q  <= next_idx(head_q);
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.scan_init) begin
        scan_ptr_q <= next_idx(head_q);
        pos_q      <= CNT_W'(1);
      end else if (cmd_i.scan_step) begin
        scan_ptr_q <= next_idx(scan_ptr_q);
        pos_q      <= pos_q + 1'b1;
      end
    end
  end

  // key and staged result
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      key_q <= in_word;
    end
    if (cmd_i.set_res) begin
      res_status_q  <= cmd_i.res_status;
      res_pos_q     <= cmd_i.res_pos ? POS_W'(pos_q) : '0;
      res_removed_q <= cmd_i.pop_done ? VALUE_W'($signed(rd_data)) : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_pos_q     <= res_pos_q;
      out_removed_q <= res_removed_q;
      out_occ_q     <= OCC_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_position_o  = out_pos_q;
  assign out_removed_o   = $signed(out_removed_q);
  assign out_occupancy_o = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above queue depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> !stat_o.full)
    else $error("write into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> !stat_o.empty)
    else $error("pop from an empty queue");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (pos_q < count_q))
    else $error("scan ran past the tail");

  a_load_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("response overwritten before taken");

endmodule

@@ sv/fifo_queue_with_search.sv @@
// Bounded FIFO of DATA_WIDTH-bit words (QUEUE_DEPTH entries) with positional
// search. Each request on req_i is a push, pop or search and yields exactly one
// response on rsp_o, in request order: status (ok, empty, full/dropped, not
// found), the 1-based match position from the head, the popped word
// (sign-extended, zero unless a pop succeeded) and the occupancy after the
// request. Requests are handled one at a time: req_i.ready is high while the
// controller is idle, even if the previous response is still waiting in the
// output register. A push, an unused code and any request on an empty queue
// go straight to the response hand-off; a pop first reads the head, and a
// search walks entries up to the match position, or the occupancy on a miss.
// The store is a RAM with one registered read port, so the search walks the
// queue from the head one entry per clock. The hand-off waits while the
// previous response has not been taken yet, and the next request is not
// accepted before it.
module fifo_queue_with_search #(
  parameter int unsigned QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fqs_req_if.sink  req_i,
  fqs_rsp_if.source rsp_o
);
  import fqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // sequencing: idle / pop read / search walk / response hand-off
  fqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_req_i   (req_i.req_type),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // pointers, count, entry store, compare and response registers
  fqs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_value_i      (req_i.value),
    .out_ready_i     (rsp_o.ready),
    .stat_o          (stat),
    .out_valid_o     (rsp_o.valid),
    .out_status_o    (rsp_o.status),
    .out_position_o  (rsp_o.position),
    .out_removed_o   (rsp_o.removed_value),
    .out_occupancy_o (rsp_o.occupancy)
  );

endmodule

@@ sim/fifo_queue_with_search_tb.sv @@
`timescale 1ns / 1ps

module fifo_queue_with_search_tb;
  import fqs_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;

  // The request code left unused by req_e; the block must treat it as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Word extremes, handy for both the directed rows and the random picks.
  localparam logic signed [VALUE_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_ONES = -32'sd1;

  // Random requests per idling phase (four phases, about 1100 in total).
  localparam int RAND_PER_PHASE = 270;
  // Cycles with no handshake on either side before we give up. The limit
  // covers a full search as well as long random stalls.
  localparam int QUIET_LIMIT = 4000;
  // Settle time after the last response, long enough for a full search.
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;

  // One response as the predictor sees it.
  typedef struct packed {
    status_e                   status;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] removed;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // One row of the directed table. A row with reps > 1 issues the same
  // request reps times, the value going up by one each time. When has_exp
  // is set the response is typed in; otherwise the predictor supplies it.
  typedef struct {
    logic [REQ_W-1:0]          kind;
    logic signed [VALUE_W-1:0] value;
    int                        reps;
    bit                        has_exp;
    rsp_t                      exp;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fqs_req_if req_if ();
  fqs_rsp_if rsp_if ();

  fifo_queue_with_search dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the queue contents, oldest word at index 0.
  logic signed [VALUE_W-1:0] held_words[$];
  // Responses still owed by the block, in request order.
  rsp_t owed_rsp[$];

  int fail_count    = 0;
  int quiet_cycles  = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int push_bias     = 50;

  // Directed part: empty-queue errors, the unused code, word extremes,
  // a match at the head of a multi-entry queue, duplicates (oldest wins),
  // a miss, filling up, a dropped push on a full queue, a match in the
  // last slot, pop of the most negative word and a tail that wraps.
  step_t directed_steps [21] = '{
    '{REQ_POP,    32'sd0,           1,  1'b1, '{ST_EMPTY,     5'd0,  32'sd0,   5'd0}},
    '{REQ_SEARCH, 32'sd0,           1,  1'b1, '{ST_EMPTY,     5'd0,  32'sd0,   5'd0}},
    '{REQ_UNUSED, WORD_ONES,        1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd0}},
    '{REQ_PUSH,   WORD_MIN,         1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd1}},
    '{REQ_PUSH,   WORD_MAX,         1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd2}},
    '{REQ_SEARCH, WORD_MIN,         1,  1'b1, '{ST_OK,        5'd1,  32'sd0,   5'd2}},
    '{REQ_PUSH,   WORD_ONES,        1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd3}},
    '{REQ_PUSH,   32'sd0,           1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd4}},
    '{REQ_PUSH,   WORD_MAX,         1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd5}},
    '{REQ_SEARCH, WORD_MAX,         1,  1'b1, '{ST_OK,        5'd2,  32'sd0,   5'd5}},
    '{REQ_SEARCH, 32'sd0,           1,  1'b1, '{ST_OK,        5'd4,  32'sd0,   5'd5}},
    '{REQ_SEARCH, 32'sh1234_5678,   1,  1'b1, '{ST_NOT_FOUND, 5'd0,  32'sd0,   5'd5}},
    '{REQ_UNUSED, 32'sh55aa_55aa,   1,  1'b1, '{ST_OK,        5'd0,  32'sd0,   5'd5}},
    '{REQ_PUSH,   32'sh0000_1000,   11, 1'b0, '{ST_OK,        5'd0,  32'sd0,   5'd0}},
    '{REQ_PUSH,   32'sh0bad_0bad,   1,  1'b1, '{ST_FULL,      5'd0,  32'sd0,   5'd16}},
    '{REQ_SEARCH, 32'sh0000_100a,   1,  1'b0, '{ST_OK,        5'd0,  32'sd0,   5'd0}},
    '{REQ_SEARCH, 32'sh0bad_0bad,   1,  1'b1, '{ST_NOT_FOUND, 5'd0,  32'sd0,   5'd16}},
    '{REQ_POP,    32'sd0,           1,  1'b1, '{ST_OK,        5'd0,  WORD_MIN, 5'd15}},
    '{REQ_PUSH,   32'sh0000_2000,   1,  1'b0, '{ST_OK,        5'd0,  32'sd0,   5'd0}},
    '{REQ_SEARCH, 32'sh0000_2000,   1,  1'b0, '{ST_OK,        5'd0,  32'sd0,   5'd0}},
    '{REQ_POP,    WORD_ONES,        1,  1'b0, '{ST_OK,        5'd0,  32'sd0,   5'd0}}
  };

  // Predictor: applies one accepted request to the shadow queue and returns
  // the response the block owes for it.
  function automatic rsp_t apply_request(input logic [REQ_W-1:0]          kind,
                                         input logic signed [VALUE_W-1:0] word);
    rsp_t r;
    bit   hit;
    r.status    = ST_OK;
    r.position  = '0;
    r.removed   = '0;
    r.occupancy = '0;
    hit         = 1'b0;
    case (kind)
      REQ_PUSH: begin
        if (held_words.size() >= DEPTH) r.status = ST_FULL;
        else held_words.push_back(word);
      end
      REQ_POP: begin
        if (held_words.size() == 0) r.status = ST_EMPTY;
        else r.removed = held_words.pop_front();
      end
      REQ_SEARCH: begin
        if (held_words.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Oldest match wins, so scan from the head and stop at the first hit.
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < held_words.size(); i++) begin
            if (!hit && held_words[i] == word) begin
              hit        = 1'b1;
              r.status   = ST_OK;
              r.position = POS_W'(i + 1);
            end
          end
        end
      end
      default: ;  // unused code: nothing changes
    endcase
    r.occupancy = OCC_W'(held_words.size());
    return r;
  endfunction

  // Random word: extremes, a tiny pool that makes duplicates likely, or
  // fully random bits.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return WORD_ONES;
          default: return '0;
        endcase
      end
      1:       return VALUE_W'($signed($urandom_range(0, 7)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // Drive one request from a falling edge, hold it until the block takes
  // it, record what the block owes, and return at the next falling edge.
  task automatic send_request(input logic [REQ_W-1:0]          kind,
                              input logic signed [VALUE_W-1:0] word,
                              input bit                        has_exp,
                              input rsp_t                      exp);
    rsp_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = kind;
    req_if.value    = word;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = apply_request(kind, word);
    if (has_exp) want = exp;
    owed_rsp.push_back(want);
    @(negedge clk_i);
  endtask

  // Random traffic. The push/pop balance swings every 32 requests so the
  // queue keeps travelling between empty and full; most searches use a key
  // that is held, so hits land at every position.
  task automatic run_random(input int count);
    rsp_t                      none;
    int                        pick;
    logic signed [VALUE_W-1:0] key;
    none = '0;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 80;
          1:       push_bias = 20;
          default: push_bias = 50;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(REQ_UNUSED, pick_word(), 1'b0, none);
      end else if (pick < 33) begin
        if (held_words.size() > 0 && $urandom_range(0, 99) < 65)
          key = held_words[$urandom_range(0, held_words.size() - 1)];
        else
          key = pick_word();
        send_request(REQ_SEARCH, key, 1'b0, none);
      end else if ($urandom_range(0, 99) < push_bias) begin
        send_request(REQ_PUSH, pick_word(), 1'b0, none);
      end else begin
        send_request(REQ_POP, pick_word(), 1'b0, none);
      end
    end
  endtask

  // Response side: ready changes only at falling edges, with the stall
  // rate of the current phase.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = rst_ni && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Compare each taken response with the oldest owed one.
  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (owed_rsp.size() == 0) begin
        if (fail_count < 10)
          $display("[%0t] response with none owed: status=%0d pos=%0d removed=%h occ=%0d",
                   $realtime, rsp_if.status, rsp_if.position, rsp_if.removed_value,
                   rsp_if.occupancy);
        fail_count++;
      end else begin
        want = owed_rsp.pop_front();
        if (rsp_if.status !== want.status || rsp_if.position !== want.position ||
            rsp_if.removed_value !== want.removed ||
            rsp_if.occupancy !== want.occupancy) begin
          if (fail_count < 10)
            $display("[%0t] mismatch: exp status=%0d pos=%0d removed=%h occ=%0d, got status=%0d pos=%0d removed=%h occ=%0d",
                     $realtime, want.status, want.position, want.removed, want.occupancy,
                     rsp_if.status, rsp_if.position, rsp_if.removed_value,
                     rsp_if.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH;
    req_if.value    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, no idling on either side.
    foreach (directed_steps[s]) begin
      for (int k = 0; k < directed_steps[s].reps; k++)
        send_request(directed_steps[s].kind, directed_steps[s].value + k,
                     directed_steps[s].has_exp, directed_steps[s].exp);
    end

    // Random phases: free flow, idle sender, stalling receiver, then both.
    run_random(RAND_PER_PHASE);
    src_idle_pct  = 54;
    snk_stall_pct = 0;
    run_random(RAND_PER_PHASE);
    src_idle_pct  = 0;
    snk_stall_pct = 54;
    run_random(RAND_PER_PHASE);
    src_idle_pct  = 28;
    snk_stall_pct = 28;
    run_random(RAND_PER_PHASE);

    req_if.valid = 1'b0;
    // The watchdog ends the run if an owed response never shows up.
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
